@@ hdl/assert_macros.svh @@
// Assertion macros used by the verification checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/gdc_pkg.sv @@
// Shared widths, constants, payload types and tables for the date conversion unit.
package gdc_pkg;

  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 25;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned STAMP_W = 41;
  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned YRD_W   = 18;
  localparam int unsigned CYC_W   = 8;
  localparam int unsigned REM_W   = 9;

  localparam logic [YEAR_W-1:0]  BASE_YEAR    = 16'd2000;
  localparam logic [EPOCH_W-1:0] EPOCH_RESET  = 32'd946684800;
  localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
  localparam logic [COUNT_W-1:0] DAYS_PER_CYCLE = 25'd146097;
  localparam logic [YRD_W-1:0]   DAYS_PER_YEAR  = 18'd365;
  localparam logic [16:0]        YEARS_PER_CYCLE = 17'd400;

  typedef struct packed {
    logic                 is_leap;
    logic [COUNT_W-1:0]   cyc_days;
    logic [YRD_W-1:0]     yr_days;
    logic [DOY_W-1:0]     doy;
  } front_t;

  typedef struct packed {
    logic                 is_leap;
    logic [COUNT_W-1:0]   total;
  } count_t;

  // Days before the first of the month in a common year.
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] s;
    unique case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/gdc_front.sv @@
// Date decode pipeline: clamping, 400-year split, leap flag and day-of-year terms.
module gdc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gdc_pkg::YEAR_W-1:0]  in_year,
  input  logic [gdc_pkg::MONTH_W-1:0] in_month,
  input  logic [gdc_pkg::DAY_W-1:0]   in_day,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gdc_pkg::front_t             out_data
);

  localparam logic [12:0] RECIP_25 = 13'd5243;

  logic                           a_valid_r, b_valid_r, c_valid_r;
  logic                           a_en, b_en, c_en;

  logic [gdc_pkg::YEAR_W-1:0]     a_since_r, a_since_nxt;
  logic [gdc_pkg::CYC_W-1:0]      a_q_r, a_q_nxt;
  logic [gdc_pkg::DOY_W-1:0]      a_ms_r, a_ms_nxt;
  logic                           a_late_r, a_late_nxt;
  logic [gdc_pkg::DAY_W-1:0]      a_day_r;

  logic [gdc_pkg::CYC_W-1:0]      b_q_r;
  logic [gdc_pkg::REM_W-1:0]      b_rem_r, b_rem_nxt;
  logic [gdc_pkg::DOY_W-1:0]      b_ms_r;
  logic                           b_late_r;
  logic [gdc_pkg::DAY_W-1:0]      b_day_r;

  gdc_pkg::front_t                c_data_r, c_data_nxt;

  logic [gdc_pkg::YEAR_W-1:0]     year_c;
  logic [gdc_pkg::MONTH_W-1:0]    month_c;
  logic [24:0]                    q_prod;
  logic [16:0]                    cyc_years;
  logic [gdc_pkg::YEAR_W-1:0]     rem_wide;
  logic                           leap;
  logic [gdc_pkg::YRD_W-1:0]      rem_days;
  logic [9:0]                     rem_up;
  logic [7:0]                     quads;
  logic [2:0]                     cents;

  assign c_en     = !c_valid_r || out_ready;
  assign b_en     = !b_valid_r || c_en;
  assign a_en     = !a_valid_r || b_en;
  assign in_ready = a_en;

  // Stage A: clamp the date, estimate the number of whole 400-year cycles and look up the month start.
  always_comb begin
    year_c = (in_year < gdc_pkg::BASE_YEAR) ? gdc_pkg::BASE_YEAR : in_year;
    priority if (in_month < gdc_pkg::MONTH_JAN) begin
      month_c = gdc_pkg::MONTH_JAN;
    end else if (in_month > gdc_pkg::MONTH_DEC) begin
      month_c = gdc_pkg::MONTH_DEC;
    end else begin
      month_c = in_month;
    end
    a_since_nxt = year_c - gdc_pkg::BASE_YEAR;
    q_prod      = {13'd0, a_since_nxt[15:4]} * {12'd0, RECIP_25};
    a_q_nxt     = q_prod[24:17];
    a_ms_nxt    = gdc_pkg::month_start(month_c);
    a_late_nxt  = month_c > gdc_pkg::MONTH_FEB;
  end

  // Stage B: year within the current cycle.
  always_comb begin
    cyc_years = {9'd0, a_q_r} * gdc_pkg::YEARS_PER_CYCLE;
    rem_wide  = a_since_r - cyc_years[15:0];
    b_rem_nxt = rem_wide[gdc_pkg::REM_W-1:0];
  end

  // Stage C: leap flag, day offsets of the cycle and year, day of year.
  always_comb begin
    leap     = (b_rem_r[1:0] == 2'd0) && (b_rem_r != 9'd100) && (b_rem_r != 9'd200)
               && (b_rem_r != 9'd300);
    rem_up   = {1'b0, b_rem_r} + 10'd3;
    quads    = rem_up[9:2];
    priority if (b_rem_r <= 9'd100) begin
      cents = 3'd1;
    end else if (b_rem_r <= 9'd200) begin
      cents = 3'd2;
    end else if (b_rem_r <= 9'd300) begin
      cents = 3'd3;
    end else begin
      cents = 3'd4;
    end
    rem_days = {9'd0, b_rem_r} * gdc_pkg::DAYS_PER_YEAR;
    c_data_nxt.is_leap  = leap;
    c_data_nxt.cyc_days = {17'd0, b_q_r} * gdc_pkg::DAYS_PER_CYCLE;
    c_data_nxt.yr_days  = (b_rem_r == 9'd0) ? 18'd0
                        : rem_days + {10'd0, quads} - {15'd0, cents} + 18'd1;
    c_data_nxt.doy      = b_ms_r + {4'd0, b_day_r} + {8'd0, leap && b_late_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_r <= in_valid;
      end
      if (b_en) begin
        b_valid_r <= a_valid_r;
      end
      if (c_en) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_since_r <= a_since_nxt;
      a_q_r     <= a_q_nxt;
      a_ms_r    <= a_ms_nxt;
      a_late_r  <= a_late_nxt;
      a_day_r   <= in_day;
    end
    if (b_en) begin
      b_q_r    <= a_q_r;
      b_rem_r  <= b_rem_nxt;
      b_ms_r   <= a_ms_r;
      b_late_r <= a_late_r;
      b_day_r  <= a_day_r;
    end
    if (c_en) begin
      c_data_r <= c_data_nxt;
    end
  end

  assign out_valid = c_valid_r;
  assign out_data  = c_data_r;

endmodule

@@ hdl/gdc_count.sv @@
// Day count stage: sums the cycle, year and day-of-year offsets with saturation at zero.
module gdc_count (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gdc_pkg::front_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output gdc_pkg::count_t out_data
);

  logic                           d_valid_r;
  logic                           d_en;
  gdc_pkg::count_t                d_data_r, d_data_nxt;
  logic [gdc_pkg::COUNT_W:0]      sum;
  logic [gdc_pkg::COUNT_W:0]      sum_m1;

  assign d_en     = !d_valid_r || out_ready;
  assign in_ready = d_en;

  // The sum is zero only for January 0 of the base year, which stays at day zero.
  always_comb begin
    sum    = {1'b0, in_data.cyc_days} + {8'd0, in_data.yr_days} + {17'd0, in_data.doy};
    sum_m1 = sum - 26'd1;
    d_data_nxt.is_leap = in_data.is_leap;
    d_data_nxt.total   = (sum == 26'd0) ? 25'd0 : sum_m1[gdc_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_en) begin
      d_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_en) begin
      d_data_r <= d_data_nxt;
    end
  end

  assign out_valid = d_valid_r;
  assign out_data  = d_data_r;

endmodule

@@ hdl/gdc_stamp.sv @@
// Output stages: weekday by modulo-7 folding and the seconds stamp.
module gdc_stamp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gdc_pkg::count_t             in_data,
  input  logic [gdc_pkg::EPOCH_W-1:0] epoch,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_leap,
  output logic [gdc_pkg::COUNT_W-1:0] out_day_count,
  output logic [gdc_pkg::WDAY_W-1:0]  out_weekday,
  output logic [gdc_pkg::STAMP_W-1:0] out_seconds_stamp
);

  localparam logic [34:0] SEC_ODD = 35'd675;

  logic                           e_valid_r, f_valid_r;
  logic                           e_en, f_en;

  logic                           e_leap_r;
  logic [gdc_pkg::COUNT_W-1:0]    e_total_r;
  logic [5:0]                     e_fold_r, e_fold_nxt;
  logic [34:0]                    e_prod_r, e_prod_nxt;

  logic                           f_leap_r;
  logic [gdc_pkg::COUNT_W-1:0]    f_total_r;
  logic [gdc_pkg::WDAY_W-1:0]     f_wday_r, f_wday_nxt;
  logic [gdc_pkg::STAMP_W-1:0]    f_secs_r, f_secs_nxt;

  logic [26:0]                    total_pad;
  logic [3:0]                     fold2;
  logic [41:0]                    secs_sum;

  // Maps a value below 15 that is congruent to the day count modulo 7 to the weekday.
  function automatic logic [gdc_pkg::WDAY_W-1:0] wday_of(input logic [3:0] f);
    logic [gdc_pkg::WDAY_W-1:0] w;
    unique case (f)
      4'd0, 4'd7, 4'd14: w = 3'd6;
      4'd1, 4'd8:        w = 3'd7;
      4'd2, 4'd9:        w = 3'd1;
      4'd3, 4'd10:       w = 3'd2;
      4'd4, 4'd11:       w = 3'd3;
      4'd5, 4'd12:       w = 3'd4;
      4'd6, 4'd13:       w = 3'd5;
      default:           w = 3'd6;
    endcase
    return w;
  endfunction

  assign f_en     = !f_valid_r || out_ready;
  assign e_en     = !e_valid_r || f_en;
  assign in_ready = e_en;

  // Since eight is one modulo seven, the octal digits sum to the same residue.
  always_comb begin
    total_pad  = {2'd0, in_data.total};
    e_fold_nxt = 6'd0;
    for (int i = 0; i < 9; i++) begin
      e_fold_nxt = e_fold_nxt + {3'd0, total_pad[3*i +: 3]};
    end
    e_prod_nxt = {10'd0, in_data.total} * SEC_ODD;
  end

  always_comb begin
    fold2      = {1'b0, e_fold_r[5:3]} + {1'b0, e_fold_r[2:0]};
    f_wday_nxt = wday_of(fold2);
    secs_sum   = {e_prod_r, 7'd0} + {10'd0, epoch};
    f_secs_nxt = secs_sum[gdc_pkg::STAMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else begin
      if (e_en) begin
        e_valid_r <= in_valid;
      end
      if (f_en) begin
        f_valid_r <= e_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_en) begin
      e_leap_r  <= in_data.is_leap;
      e_total_r <= in_data.total;
      e_fold_r  <= e_fold_nxt;
      e_prod_r  <= e_prod_nxt;
    end
    if (f_en) begin
      f_leap_r  <= e_leap_r;
      f_total_r <= e_total_r;
      f_wday_r  <= f_wday_nxt;
      f_secs_r  <= f_secs_nxt;
    end
  end

  assign out_valid         = f_valid_r;
  assign out_is_leap       = f_leap_r;
  assign out_day_count     = f_total_r;
  assign out_weekday       = f_wday_r;
  assign out_seconds_stamp = f_secs_r;

endmodule

@@ hdl/gregorian_date_to_day_count_unit.sv @@
// Top level of the Gregorian date to day count, weekday and seconds stamp converter.
//
// A date (in_year, in_month, in_day) is one input transaction on in_valid/in_ready.
// Each date yields one result transaction on out_valid/out_ready carrying the leap
// flag, the days since 2000-01-01, the weekday (1 is Monday) and the seconds stamp.
// Years below 2000 count as 2000 and months outside 1 to 12 are clamped.
// The datapath is a six-stage pipeline: date decode (three stages), day count
// (one stage) and weekday/seconds (two stages). One date is accepted every cycle
// unless a stalled receiver backs the pipeline up. Each stage holds a valid bit
// and loads when it is empty or its successor loads, so a stalled receiver backs
// the pipeline up without losing transactions; in_ready drops only when all six
// stages hold data and out_ready is low. The epoch offset is written through
// cfg_wr_en/cfg_wr_data and is added in the last stage, so the user must change it
// only while no transaction is in flight; the block does not enforce this.
// Reset empties the pipeline and sets the epoch offset to 946684800.
module gregorian_date_to_day_count_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gdc_pkg::YEAR_W-1:0]  in_year,
  input  logic [gdc_pkg::MONTH_W-1:0] in_month,
  input  logic [gdc_pkg::DAY_W-1:0]   in_day,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_leap,
  output logic [gdc_pkg::COUNT_W-1:0] out_day_count,
  output logic [gdc_pkg::WDAY_W-1:0]  out_weekday,
  output logic [gdc_pkg::STAMP_W-1:0] out_seconds_stamp,
  input  logic                        cfg_wr_en,
  input  logic [gdc_pkg::EPOCH_W-1:0] cfg_wr_data
);

  logic [gdc_pkg::EPOCH_W-1:0] epoch_r;
  logic                        front_valid, front_ready;
  gdc_pkg::front_t             front_data;
  logic                        count_valid, count_ready;
  gdc_pkg::count_t             count_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= gdc_pkg::EPOCH_RESET;
    end else if (cfg_wr_en) begin
      epoch_r <= cfg_wr_data;
    end
  end

  gdc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  gdc_count u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (count_valid),
    .out_ready (count_ready),
    .out_data  (count_data)
  );

  gdc_stamp u_stamp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (count_valid),
    .in_ready          (count_ready),
    .in_data           (count_data),
    .epoch             (epoch_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_leap       (out_is_leap),
    .out_day_count     (out_day_count),
    .out_weekday       (out_weekday),
    .out_seconds_stamp (out_seconds_stamp)
  );

endmodule

@@ hdl/gdc_checker.sv @@
// Port-level assertion checker for the date conversion unit, bound to the top level.
`include "assert_macros.svh"

module gdc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [gdc_pkg::COUNT_W-1:0] out_day_count,
  input  logic [gdc_pkg::WDAY_W-1:0]  out_weekday
);

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  `ASSERT_CLK(a_first_day, out_valid && (out_day_count == 25'd0) |-> (out_weekday == 3'd6), "day zero must be a Saturday")

  `ASSERT_CLK(a_wday_range, out_valid |-> (out_weekday != 3'd0), "weekday out of range")

  `ASSERT_ALWAYS(a_reset_empty, rst_n && !$past(rst_n) |-> !out_valid, "result present after reset")

endmodule

bind gregorian_date_to_day_count_unit gdc_checker u_gdc_checker (.*);
